// ===== rtl/kca_pkg.sv =====
// ----------------------------------------------------------------------------
// kca_pkg
// Shared types, constants and the key mask table for the key click and
// autorepeat block.
// ----------------------------------------------------------------------------
package kca_pkg;

   localparam int KEY_BITS     = 13;
   localparam int KEY_W        = 4;
   localparam int TIME_W       = 32;
   localparam int DELAY_W      = 16;
   localparam int TABLE_SLOTS  = 15;
   localparam int NUM_KEYS_DEF = 11;
   localparam int CSR_IDX_W    = 1;

   localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = DELAY_W'(500);
   localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = DELAY_W'(175);

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_DELAY = CSR_IDX_W'(1);

   localparam logic CMD_SCAN   = 1'b0;
   localparam logic CMD_FORGET = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [KEY_BITS-1:0] key_word;
      logic [TIME_W-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             is_repeat;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] prev_keys;
      logic [KEY_W-1:0]    held_key;
   } scan_state_type;

   typedef struct packed {
      logic             clicked;
      logic [KEY_W-1:0] click_key;
      logic             held_down;
   } click_type;

   // Mask of table slot n (entry n + 1); slots past the eleventh are empty.
   function automatic logic [KEY_BITS-1:0] key_mask(input logic [KEY_W-1:0] slot);
      logic [KEY_BITS-1:0] mask;
      unique case (slot)
         4'd0:    mask = 13'h0001;
         4'd1:    mask = 13'h0002;
         4'd2:    mask = 13'h0008;
         4'd3:    mask = 13'h0004;
         4'd4:    mask = 13'h0100;
         4'd5:    mask = 13'h0030;
         4'd6:    mask = 13'h0020;
         4'd7:    mask = 13'h0010;
         4'd8:    mask = 13'h0400;
         4'd9:    mask = 13'h0200;
         4'd10:   mask = 13'h1000;
         default: mask = '0;
      endcase
      return mask;
   endfunction

endpackage

// ===== rtl/kca_stream_if.sv =====
// ----------------------------------------------------------------------------
// kca_stream_if
// Valid/ready channel carrying one beat of a packed payload.
// ----------------------------------------------------------------------------
interface kca_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/kca_click.sv =====
// ----------------------------------------------------------------------------
// kca_click
// Priority search of the key mask table for a click, and the check that the
// held key is still fully pressed.
// ----------------------------------------------------------------------------
module kca_click #(
   parameter int NUM_KEYS = kca_pkg::NUM_KEYS_DEF
) (
   input  logic [kca_pkg::KEY_BITS-1:0] key_word,
   input  kca_pkg::scan_state_type      scan_state,
   output kca_pkg::click_type           click
);

   logic [kca_pkg::KEY_BITS-1:0] held_mask;

   assign held_mask = kca_pkg::key_mask(kca_pkg::KEY_W'(scan_state.held_key - 1'b1));

   always_comb begin
      click.clicked   = 1'b0;
      click.click_key = '0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (((scan_state.prev_keys & kca_pkg::key_mask(kca_pkg::KEY_W'(i))) != '0) &&
             ((key_word & kca_pkg::key_mask(kca_pkg::KEY_W'(i))) == '0)) begin
            click.clicked   = 1'b1;
            click.click_key = kca_pkg::KEY_W'(i + 1);
         end
      end
      click.held_down = (scan_state.held_key != '0) && ((key_word & held_mask) == '0);
   end

endmodule

// ===== rtl/kca_state.sv =====
// ----------------------------------------------------------------------------
// kca_state
// Held key, repeat timing and previous scan state, with the result of each
// beat.
// ----------------------------------------------------------------------------
module kca_state (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  kca_pkg::req_type              item,
   input  kca_pkg::click_type            click,
   input  logic [kca_pkg::DELAY_W-1:0]   first_delay,
   input  logic [kca_pkg::DELAY_W-1:0]   repeat_delay,
   output kca_pkg::scan_state_type       scan_state,
   output kca_pkg::rsp_type              result
);

   logic [kca_pkg::KEY_BITS-1:0] prev_keys_ff, prev_keys_in;
   logic [kca_pkg::KEY_W-1:0]    held_key_ff, held_key_in;
   logic [kca_pkg::TIME_W-1:0]   last_time_ff, last_time_in;
   logic                         repeated_ff, repeated_in;
   logic [kca_pkg::TIME_W-1:0]   elapsed;
   logic [kca_pkg::DELAY_W-1:0]  limit;
   logic                         due;

   assign elapsed = item.now_ms - last_time_ff;
   assign limit   = repeated_ff ? repeat_delay : first_delay;
   assign due     = !elapsed[kca_pkg::TIME_W-1] &&
                    (elapsed > kca_pkg::TIME_W'(limit));

   always_comb begin
      prev_keys_in     = prev_keys_ff;
      held_key_in      = held_key_ff;
      last_time_in     = last_time_ff;
      repeated_in      = repeated_ff;
      result.key       = '0;
      result.is_repeat = 1'b0;
      if (item.cmd == kca_pkg::CMD_FORGET) begin
         held_key_in = '0;
      end else begin
         prev_keys_in = item.key_word;
         priority if (click.clicked) begin
            held_key_in  = click.click_key;
            repeated_in  = 1'b0;
            last_time_in = item.now_ms;
            result.key   = click.click_key;
         end else if (click.held_down) begin
            if (due) begin
               repeated_in      = 1'b1;
               last_time_in     = item.now_ms;
               result.key       = held_key_ff;
               result.is_repeat = 1'b1;
            end
         end else begin
            held_key_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_keys_ff <= '0;
         held_key_ff  <= '0;
         last_time_ff <= '0;
         repeated_ff  <= 1'b0;
      end else if (advance) begin
         prev_keys_ff <= prev_keys_in;
         held_key_ff  <= held_key_in;
         last_time_ff <= last_time_in;
         repeated_ff  <= repeated_in;
      end
   end

   assign scan_state.prev_keys = prev_keys_ff;
   assign scan_state.held_key  = held_key_ff;

endmodule

// ===== rtl/key_click_autorepeat_top.sv =====
// ----------------------------------------------------------------------------
// key_click_autorepeat_top
// Detects key clicks in active-low scan words and produces autorepeat reports
// for the held key.
//
//   Channel | Dir | Beat contents
//   req     | in  | cmd, key_word, now_ms
//   rsp     | out | key, is_repeat
//   csr     | in  | first_delay (index 0), repeat_delay (index 1)
//
// A beat is taken into an input register, evaluated combinationally against
// the held state and written to the result register, from which it is
// offered on rsp.
// One beat is accepted per cycle while the result register is free or drained.
// A stalled result holds the input register and then back-pressure reaches req.
// Synchronous reset clears the held key and timing state and restores both
// delays to their defaults.
// ----------------------------------------------------------------------------
module key_click_autorepeat_top #(
   parameter int NUM_KEYS = kca_pkg::NUM_KEYS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   kca_stream_if.sink                      req,
   kca_stream_if.source                    rsp,
   input  logic                            csr_we,
   input  logic [kca_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kca_pkg::DELAY_W-1:0]     csr_wdata
);

   logic                         in_valid_ff;
   kca_pkg::req_type             in_data_ff;
   logic                         out_valid_ff, out_valid_in;
   kca_pkg::rsp_type             out_data_ff;
   logic [kca_pkg::DELAY_W-1:0]  first_delay_ff;
   logic [kca_pkg::DELAY_W-1:0]  repeat_delay_ff;
   logic                         advance;
   kca_pkg::scan_state_type      scan_state;
   kca_pkg::click_type           click;
   kca_pkg::rsp_type             result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff  <= kca_pkg::FIRST_DELAY_RST;
         repeat_delay_ff <= kca_pkg::REPEAT_DELAY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            kca_pkg::CSR_FIRST_DELAY:  first_delay_ff  <= csr_wdata;
            kca_pkg::CSR_REPEAT_DELAY: repeat_delay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_data_ff <= req.payload;
      end
   end

   kca_click #(
      .NUM_KEYS (NUM_KEYS)
   ) u_click (
      .key_word   (in_data_ff.key_word),
      .scan_state (scan_state),
      .click      (click)
   );

   kca_state u_state (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (in_data_ff),
      .click        (click),
      .first_delay  (first_delay_ff),
      .repeat_delay (repeat_delay_ff),
      .scan_state   (scan_state),
      .result       (result)
   );

   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_data_ff;

   a_repeat_has_key : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.is_repeat |-> rsp.payload.key != '0)
      else $error("repeat report without a key");

   a_key_in_table : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.key <= kca_pkg::KEY_W'(NUM_KEYS))
      else $error("reported key beyond the table");

   a_forget_clears : assert property (@(posedge clock) disable iff (reset)
      advance && (in_data_ff.cmd == kca_pkg::CMD_FORGET) |=> scan_state.held_key == '0)
      else $error("held key survived a forget command");

   a_stall_holds_input : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost a beat while stalled");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key click and autorepeat block. Scan and forget
// beats are driven with random idling on both channels and one long result
// stall. Every beat accepted on req is run through a cycle-free model of click
// priority and repeat timing, and each rsp beat is checked against the oldest
// predicted report. Delays are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kca_pkg::*;

   localparam int ENTRIES     = NUM_KEYS_DEF;
   localparam int CYCLE_LIMIT = 200000;

   class key_report_scoreboard;
      logic [KEY_BITS-1:0] entry_mask [ENTRIES];
      logic [KEY_BITS-1:0] last_scan;
      logic [KEY_W-1:0]    armed_key;
      logic [TIME_W-1:0]   report_ms;
      logic                repeat_done;
      logic [DELAY_W-1:0]  first_ms;
      logic [DELAY_W-1:0]  repeat_ms;
      rsp_type             due_reports [$];
      int                  errors;

      function new();
         entry_mask  = '{13'h0001, 13'h0002, 13'h0008, 13'h0004, 13'h0100, 13'h0030,
                         13'h0020, 13'h0010, 13'h0400, 13'h0200, 13'h1000};
         last_scan   = '0;
         armed_key   = '0;
         report_ms   = '0;
         repeat_done = 1'b0;
         first_ms    = FIRST_DELAY_RST;
         repeat_ms   = REPEAT_DELAY_RST;
         errors      = 0;
      endfunction

      function void set_delay(input logic [CSR_IDX_W-1:0] idx, input logic [DELAY_W-1:0] ms);
         if (idx == CSR_FIRST_DELAY) begin
            first_ms = ms;
         end else begin
            repeat_ms = ms;
         end
      endfunction

      function void predict_report(input req_type beat);
         rsp_type             want;
         logic [KEY_W-1:0]    clicked;
         logic [TIME_W-1:0]   elapsed;
         logic [DELAY_W-1:0]  wait_ms;
         want    = '0;
         clicked = '0;
         if (beat.cmd == CMD_FORGET) begin
            armed_key = '0;
         end else begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (clicked == 0 && (last_scan & entry_mask[i]) != 0 &&
                   (beat.key_word & entry_mask[i]) == 0) begin
                  clicked = KEY_W'(i + 1);
               end
            end
            if (clicked != 0) begin
               armed_key   = clicked;
               repeat_done = 1'b0;
               report_ms   = beat.now_ms;
               want.key    = clicked;
            end else if (armed_key != 0 &&
                         (beat.key_word & entry_mask[armed_key - 1]) == 0) begin
               elapsed = beat.now_ms - report_ms;
               wait_ms = repeat_done ? repeat_ms : first_ms;
               if (!elapsed[TIME_W-1] && elapsed > TIME_W'(wait_ms)) begin
                  repeat_done    = 1'b1;
                  report_ms      = beat.now_ms;
                  want.key       = armed_key;
                  want.is_repeat = 1'b1;
               end
            end else begin
               armed_key = '0;
            end
            last_scan = beat.key_word;
         end
         due_reports.push_back(want);
      endfunction

      task report(input string msg);
         $display("%0t ns: mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_report(input rsp_type got);
         rsp_type want;
         if (due_reports.size() == 0) begin
            report($sformatf("report key=%0d repeat=%0b with none pending",
                             got.key, got.is_repeat));
            return;
         end
         want = due_reports.pop_front();
         if (got.key !== want.key) begin
            report($sformatf("key %0d, predicted %0d", got.key, want.key));
         end
         if (got.is_repeat !== want.is_repeat) begin
            report($sformatf("is_repeat %0b, predicted %0b", got.is_repeat, want.is_repeat));
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DELAY_W-1:0]   csr_wdata;
   logic                 calm;
   logic                 hold_off;
   logic [TIME_W-1:0]    scan_ms;
   int                   n_sent;
   int                   n_forgets;
   int                   n_clicks;
   int                   n_repeats;
   int                   cycle_count;
   key_report_scoreboard sb = new();

   kca_stream_if #(.payload_type(req_type)) req_ch ();
   kca_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   key_click_autorepeat_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_ch.payload.is_repeat) begin
               n_repeats++;
            end else if (rsp_ch.payload.key != 0) begin
               n_clicks++;
            end
            sb.check_report(rsp_ch.payload);
         end
         rsp_ch.ready <= !hold_off && (calm || $urandom_range(99) >= 24);
      end
   end

   initial begin
      hold_off <= 1'b0;
      wait (n_sent >= 400);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (120) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic send_item(input req_type beat);
      while (!calm && $urandom_range(99) < 24) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= beat;
      do @(posedge clock); while (!req_ch.ready);
      sb.predict_report(beat);
      n_sent++;
   endtask

   task automatic send_scan(input logic [KEY_BITS-1:0] word, input logic [TIME_W-1:0] ms);
      req_type beat;
      beat.cmd      = CMD_SCAN;
      beat.key_word = word;
      beat.now_ms   = ms;
      send_item(beat);
   endtask

   task automatic send_forget(input logic [KEY_BITS-1:0] word, input logic [TIME_W-1:0] ms);
      req_type beat;
      beat.cmd      = CMD_FORGET;
      beat.key_word = word;
      beat.now_ms   = ms;
      n_forgets++;
      send_item(beat);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.due_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_delays(input logic [DELAY_W-1:0] first, input logic [DELAY_W-1:0] rep);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIRST_DELAY;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= CSR_REPEAT_DELAY;
      csr_wdata <= rep;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_delay(CSR_FIRST_DELAY, first);
      sb.set_delay(CSR_REPEAT_DELAY, rep);
   endtask

   function automatic logic [TIME_W-1:0] advance(input int step_max);
      if ($urandom_range(99) < 3) begin
         scan_ms += $urandom;
      end else begin
         scan_ms += $urandom_range(0, step_max);
      end
      return scan_ms;
   endfunction

   task automatic key_burst(input int step_max);
      int                  slot;
      int                  hold;
      logic [KEY_BITS-1:0] m;
      logic [KEY_BITS-1:0] base;
      logic [KEY_BITS-1:0] down;
      logic [KEY_BITS-1:0] lift;
      slot = $urandom_range(0, ENTRIES - 1);
      m    = sb.entry_mask[slot];
      base = 13'h1FFF;
      if ($urandom_range(3) == 0) begin
         base = base & KEY_BITS'($urandom);
      end
      send_scan(base | m, advance(step_max));
      down = base & ~m;
      hold = $urandom_range(1, 12);
      repeat (hold) begin
         if ($urandom_range(19) == 0) begin
            send_forget(KEY_BITS'($urandom), advance(step_max));
         end else if ($urandom_range(9) == 0) begin
            send_scan(down ^ (KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1)),
                      advance(step_max));
         end else begin
            send_scan(down, advance(step_max));
         end
      end
      lift = m & KEY_BITS'($urandom);
      if (lift == 0) begin
         lift = m;
      end
      send_scan(down | lift, advance(step_max));
   endtask

   initial begin
      int                 step_max;
      int                 target;
      int                 waited;
      logic [DELAY_W-1:0] first;
      logic [DELAY_W-1:0] rep;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_FIRST_DELAY;
      csr_wdata      <= '0;
      calm           <= 1'b0;
      scan_ms        = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_delays(FIRST_DELAY_RST, REPEAT_DELAY_RST);

      // Timing edges, a backward step, a forget, a wrapped clock, multi-bit masks
      // and priority between entries that click together.
      send_scan(13'h1FFF, 32'd0);
      send_scan(13'h0000, 32'd10);
      send_scan(13'h0000, 32'd510);
      send_scan(13'h0000, 32'd511);
      send_scan(13'h0000, 32'd686);
      send_scan(13'h0000, 32'd687);
      send_scan(13'h0000, 32'd100);
      send_forget(13'h1FFF, 32'hFFFF_FFFF);
      send_scan(13'h1FFF, 32'h0000_0000);
      send_scan(13'h1FCF, 32'hFFFF_FF00);
      send_scan(13'h1FCF, 32'h0000_0100);
      send_scan(13'h1FDF, 32'h0000_0110);
      send_scan(13'h1FFF, 32'hFFFF_FFFF);
      send_scan(13'h1FEF, 32'h0000_0200);
      send_scan(13'h0000, 32'h0000_0300);
      send_scan(13'h1FFF, 32'h0000_0400);
      send_scan(13'h0FFF, 32'h0000_0500);
      send_scan(13'h1DFF, 32'h0000_0600);
      drain();
      set_delays('0, '0);
      send_scan(13'h1DFF, 32'h0000_0600);
      send_scan(13'h1DFF, 32'h0000_0601);
      send_scan(13'h1DFF, 32'h0000_0602);
      send_scan(13'h1FFF, 32'h0000_0603);

      scan_ms = $urandom;
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: begin
               first = FIRST_DELAY_RST;
               rep   = REPEAT_DELAY_RST;
            end
            1: begin
               first = '0;
               rep   = '0;
            end
            2: begin
               first = '1;
               rep   = '1;
            end
            3: begin
               first = DELAY_W'($urandom_range(0, 2000));
               rep   = DELAY_W'($urandom_range(0, 2000));
            end
            default: begin
               first = DELAY_W'($urandom);
               rep   = DELAY_W'($urandom);
            end
         endcase
         set_delays(first, rep);
         calm     <= (phase == 1);
         step_max = ((first > rep) ? int'(first) : int'(rep)) / 2 + 8;
         target   = n_sent + 205;
         while (n_sent < target) begin
            if ($urandom_range(99) < 15) begin
               if ($urandom_range(3) == 0) begin
                  send_forget(KEY_BITS'($urandom), advance(step_max));
               end else begin
                  send_scan(KEY_BITS'($urandom), advance(step_max));
               end
            end else begin
               key_burst(step_max);
            end
         end
      end

      req_ch.valid <= 1'b0;
      waited = 0;
      while (sb.due_reports.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (sb.due_reports.size() != 0) begin
         sb.report($sformatf("%0d predicted reports never arrived", sb.due_reports.size()));
      end
      $display("Drove %0d beats over seven delay settings, %0d of them forget commands.",
               n_sent, n_forgets);
      $display("Checked %0d fresh clicks and %0d autorepeats, with one long result stall.",
               n_clicks, n_repeats);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
